[design/dsc_pkg.sv]
package dsc_pkg;

   // kinds of input item
   typedef enum logic [1:0] {
      ITEM_BEGIN = 2'd0,
      ITEM_NAV   = 2'd1,
      ITEM_TICK  = 2'd2,
      ITEM_STOP  = 2'd3
   } item_kind_type;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_MAX_VELOCITY = 3'd0,
      CSR_PULSES_PER_M = 3'd1,
      CSR_HEADING_GAIN = 3'd2,
      CSR_LATERAL_GAIN = 3'd3,
      CSR_MAX_STEERING = 3'd4,
      CSR_STEER_SIGN   = 3'd5,
      CSR_TIMEOUT      = 3'd6
   } csr_index_type;

   // configuration reset values
   localparam logic [11:0] RST_MAX_VELOCITY = 12'd1000;
   localparam logic [15:0] RST_PULSES_PER_M = 16'd1000;
   localparam logic [15:0] RST_HEADING_GAIN = 16'd256;
   localparam logic [15:0] RST_LATERAL_GAIN = 16'd256;
   localparam logic [15:0] RST_MAX_STEERING = 16'd500;
   localparam logic        RST_STEER_SIGN   = 1'b0;
   localparam logic [15:0] RST_TIMEOUT      = 16'd50;

   // heading wrap limits in 1/64 degree
   localparam logic signed [15:0] WRAP_HALF = 16'sd11520;
   localparam logic signed [15:0] WRAP_FULL = 16'sd23040;

   // floor division by 1000: bias to positive, reciprocal multiply, unbias
   localparam logic [29:0] DIV_BIAS     = 30'd268436000;
   localparam logic [20:0] DIV_BIAS_QUO = 21'd268436;
   localparam logic [30:0] DIV_RECIP    = 31'd1099511628;

   // fields that ride along with an item through the arithmetic stages
   typedef struct packed {
      logic               drive_enable;
      logic [1:0]         control_mode;
      logic signed [14:0] hold_error;
   } tag_type;

   // one result item
   typedef struct packed {
      logic               drive_enable;
      logic signed [19:0] left_freq_hz;
      logic signed [19:0] right_freq_hz;
      logic [1:0]         control_mode;
      logic signed [14:0] heading_hold_error;
   } result_type;

endpackage

[design/differential_steering_controller_unit.sv]
// results pass the input, operand, multiply, combine and divide stages to the queue
// throughput: one item per cycle; an 8-entry result queue covers the five
//   pipeline stages, and req_stall rises only when every queue slot is claimed
// navigation commands update state in the first stage and give no result
// reset (synchronous): registers to defaults, mode stopped, pipeline and queue empty
module differential_steering_controller_unit
   import dsc_pkg::*;
#(
   parameter int OUT_DEPTH = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_mode,
   input  logic signed [15:0] req_velocity_mm_s,
   input  logic signed [14:0] req_heading_error,
   input  logic signed [15:0] req_lateral_error_mm,
   input  logic signed [14:0] req_imu_heading,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_drive_enable,
   output logic signed [19:0] rsp_left_freq_hz,
   output logic signed [19:0] rsp_right_freq_hz,
   output logic [1:0]         rsp_control_mode,
   output logic signed [14:0] rsp_heading_hold_error,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wr_data
);

   localparam int PTR_W = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
   localparam int CNT_W = $clog2(OUT_DEPTH + 1);

   typedef enum logic [1:0] {
      RUN_STOPPED = 2'd0,
      RUN_VISUAL  = 2'd1,
      RUN_HOLD    = 2'd2
   } run_mode_type;

   // floor(n / 1000) for a signed 29-bit value
   function automatic logic signed [19:0] floor_div1000(input logic signed [28:0] n);
      logic [29:0] biased;
      logic [60:0] prod;
      logic [20:0] quot;
      logic [20:0] diff;
      biased = {n[28], n} + DIV_BIAS;
      prod   = {31'd0, biased} * {30'd0, DIV_RECIP};
      quot   = prod[60:40];
      diff   = quot - DIV_BIAS_QUO;
      return diff[19:0];
   endfunction

   // configuration registers
   logic [11:0] cfg_max_velocity_ff;
   logic [15:0] cfg_pulses_ff;
   logic [15:0] cfg_heading_gain_ff;
   logic [15:0] cfg_lateral_gain_ff;
   logic [15:0] cfg_max_steer_ff;
   logic        cfg_steer_sign_ff;
   logic [15:0] cfg_timeout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_max_velocity_ff <= RST_MAX_VELOCITY;
         cfg_pulses_ff       <= RST_PULSES_PER_M;
         cfg_heading_gain_ff <= RST_HEADING_GAIN;
         cfg_lateral_gain_ff <= RST_LATERAL_GAIN;
         cfg_max_steer_ff    <= RST_MAX_STEERING;
         cfg_steer_sign_ff   <= RST_STEER_SIGN;
         cfg_timeout_ff      <= RST_TIMEOUT;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MAX_VELOCITY: cfg_max_velocity_ff <= csr_wr_data[11:0];
            CSR_PULSES_PER_M: cfg_pulses_ff       <= csr_wr_data;
            CSR_HEADING_GAIN: cfg_heading_gain_ff <= csr_wr_data;
            CSR_LATERAL_GAIN: cfg_lateral_gain_ff <= csr_wr_data;
            CSR_MAX_STEERING: cfg_max_steer_ff    <= csr_wr_data;
            CSR_STEER_SIGN:   cfg_steer_sign_ff   <= csr_wr_data[0];
            CSR_TIMEOUT:      cfg_timeout_ff      <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // handshakes and queue credit
   logic             req_acc;
   logic             rsp_acc;
   logic             nav_retire;
   logic [CNT_W-1:0] credit_ff;
   logic [CNT_W-1:0] credit_in;

   assign req_stall  = (credit_ff == CNT_W'(OUT_DEPTH));
   assign req_acc    = req_valid && !req_stall;
   assign rsp_acc    = rsp_valid && !rsp_stall;

   // input register
   logic               in_valid_ff;
   logic [1:0]         in_mode_ff;
   logic signed [15:0] in_velocity_ff;
   logic signed [14:0] in_heading_ff;
   logic signed [15:0] in_lateral_ff;
   logic signed [14:0] in_imu_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= req_acc;
      end
      if (req_acc) begin
         in_mode_ff     <= req_mode;
         in_velocity_ff <= req_velocity_mm_s;
         in_heading_ff  <= req_heading_error;
         in_lateral_ff  <= req_lateral_error_mm;
         in_imu_ff      <= req_imu_heading;
      end
   end

   assign nav_retire = in_valid_ff && (in_mode_ff == ITEM_NAV);

   // controller state
   run_mode_type       run_mode_ff, run_mode_in;
   logic signed [12:0] cmd_velocity_ff, cmd_velocity_in;
   logic signed [14:0] stored_heading_ff, stored_heading_in;
   logic signed [15:0] stored_lateral_ff, stored_lateral_in;
   logic signed [14:0] target_heading_ff, target_heading_in;
   logic signed [14:0] hold_error_ff, hold_error_in;
   logic [15:0]        command_age_ff, command_age_in;

   // operands handed to the multiply stage
   logic               op_valid_ff, op_valid_in;
   tag_type            op_tag_ff, op_tag_in;
   logic               op_visual_ff, op_visual_in;
   logic signed [12:0] op_velocity_ff, op_velocity_in;
   logic signed [14:0] op_heading_ff, op_heading_in;
   logic signed [15:0] op_lateral_ff, op_lateral_in;

   logic [15:0]        age_inc;
   logic               fresh;
   logic signed [14:0] hold_target;
   logic signed [15:0] heading_diff;
   logic signed [15:0] heading_wrap;
   logic signed [14:0] hold_new;
   logic signed [16:0] vel_ext;
   logic signed [16:0] vel_lim;
   logic signed [16:0] vel_clamped;

   // age, wrap and velocity clamp
   always_comb begin
      age_inc      = (command_age_ff == 16'hFFFF) ? command_age_ff : command_age_ff + 16'd1;
      fresh        = (age_inc <= cfg_timeout_ff);
      hold_target  = (run_mode_ff == RUN_VISUAL) ? in_imu_ff : target_heading_ff;
      heading_diff = {hold_target[14], hold_target} - {in_imu_ff[14], in_imu_ff};
      if (heading_diff > WRAP_HALF) begin
         heading_wrap = heading_diff - WRAP_FULL;
      end else if (heading_diff < -WRAP_HALF) begin
         heading_wrap = heading_diff + WRAP_FULL;
      end else begin
         heading_wrap = heading_diff;
      end
      hold_new = heading_wrap[14:0];
      vel_ext  = {in_velocity_ff[15], in_velocity_ff};
      vel_lim  = {5'd0, cfg_max_velocity_ff};
      if (vel_ext > vel_lim) begin
         vel_clamped = vel_lim;
      end else if (vel_ext < -vel_lim) begin
         vel_clamped = -vel_lim;
      end else begin
         vel_clamped = vel_ext;
      end
   end

   // state update and result operands for the item in the input register
   always_comb begin
      run_mode_in       = run_mode_ff;
      cmd_velocity_in   = cmd_velocity_ff;
      stored_heading_in = stored_heading_ff;
      stored_lateral_in = stored_lateral_ff;
      target_heading_in = target_heading_ff;
      hold_error_in     = hold_error_ff;
      command_age_in    = command_age_ff;
      op_valid_in       = 1'b0;
      op_tag_in         = '{drive_enable: 1'b0, control_mode: RUN_STOPPED,
                            hold_error: hold_error_ff};
      op_visual_in      = 1'b0;
      op_velocity_in    = '0;
      op_heading_in     = '0;
      op_lateral_in     = '0;
      if (in_valid_ff) begin
         unique case (in_mode_ff)
            ITEM_BEGIN, ITEM_STOP: begin
               run_mode_in       = RUN_STOPPED;
               cmd_velocity_in   = '0;
               stored_heading_in = '0;
               stored_lateral_in = '0;
               hold_error_in     = '0;
               command_age_in    = '0;
               if (in_mode_ff == ITEM_BEGIN) begin
                  target_heading_in = in_imu_ff;
               end
               op_valid_in          = 1'b1;
               op_tag_in.hold_error = '0;
            end
            ITEM_NAV: begin
               cmd_velocity_in   = vel_clamped[12:0];
               stored_heading_in = in_heading_ff;
               stored_lateral_in = in_lateral_ff;
               command_age_in    = '0;
               run_mode_in       = RUN_VISUAL;
            end
            ITEM_TICK: begin
               command_age_in = age_inc;
               op_valid_in    = 1'b1;
               if (run_mode_ff == RUN_STOPPED) begin
                  run_mode_in = RUN_STOPPED;
               end else if (run_mode_ff == RUN_VISUAL && fresh) begin
                  op_tag_in.drive_enable = 1'b1;
                  op_tag_in.control_mode = RUN_VISUAL;
                  op_visual_in           = 1'b1;
                  op_velocity_in         = cmd_velocity_ff;
                  op_heading_in          = stored_heading_ff;
                  op_lateral_in          = stored_lateral_ff;
               end else begin
                  // stale command or already holding heading
                  if (run_mode_ff == RUN_VISUAL) begin
                     target_heading_in = in_imu_ff;
                     stored_heading_in = '0;
                     stored_lateral_in = '0;
                  end
                  run_mode_in            = RUN_HOLD;
                  hold_error_in          = hold_new;
                  op_tag_in.drive_enable = 1'b1;
                  op_tag_in.control_mode = RUN_HOLD;
                  op_tag_in.hold_error   = hold_new;
                  op_velocity_in         = cmd_velocity_ff;
                  op_heading_in          = hold_new;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_mode_ff       <= RUN_STOPPED;
         cmd_velocity_ff   <= '0;
         stored_heading_ff <= '0;
         stored_lateral_ff <= '0;
         target_heading_ff <= '0;
         hold_error_ff     <= '0;
         command_age_ff    <= '0;
         op_valid_ff       <= 1'b0;
      end else begin
         run_mode_ff       <= run_mode_in;
         cmd_velocity_ff   <= cmd_velocity_in;
         stored_heading_ff <= stored_heading_in;
         stored_lateral_ff <= stored_lateral_in;
         target_heading_ff <= target_heading_in;
         hold_error_ff     <= hold_error_in;
         command_age_ff    <= command_age_in;
         op_valid_ff       <= op_valid_in;
      end
      op_tag_ff      <= op_tag_in;
      op_visual_ff   <= op_visual_in;
      op_velocity_ff <= op_velocity_in;
      op_heading_ff  <= op_heading_in;
      op_lateral_ff  <= op_lateral_in;
   end

   // multiply stage: base product and both gain products
   logic               pr_valid_ff;
   tag_type            pr_tag_ff;
   logic               pr_visual_ff;
   logic signed [28:0] pr_base_ff;
   logic signed [31:0] pr_head_ff, pr_head_in;
   logic signed [31:0] pr_lat_ff, pr_lat_in;
   logic signed [29:0] base_prod;

   assign base_prod  = $signed({{17{op_velocity_ff[12]}}, op_velocity_ff})
                     * $signed({14'd0, cfg_pulses_ff});
   assign pr_head_in = $signed({{17{op_heading_ff[14]}}, op_heading_ff})
                     * $signed({16'd0, cfg_heading_gain_ff});
   assign pr_lat_in  = $signed({{16{op_lateral_ff[15]}}, op_lateral_ff})
                     * $signed({16'd0, cfg_lateral_gain_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         pr_valid_ff <= 1'b0;
      end else begin
         pr_valid_ff <= op_valid_ff;
      end
      pr_tag_ff    <= op_tag_ff;
      pr_visual_ff <= op_visual_ff;
      pr_base_ff   <= base_prod[28:0];
      pr_head_ff   <= pr_head_in;
      pr_lat_ff    <= pr_lat_in;
   end

   // combine stage: scale visual by 1000 and 64, apply sign, drop 14 fraction bits
   logic               sc_valid_ff;
   tag_type            sc_tag_ff;
   logic               sc_visual_ff;
   logic signed [28:0] sc_base_ff;
   logic signed [27:0] sc_num_ff;
   logic signed [41:0] head_ext;
   logic signed [41:0] lat_ext;
   logic signed [41:0] vis_sum;
   logic signed [41:0] num_sel;
   logic signed [41:0] num_signed;

   always_comb begin
      head_ext   = {{10{pr_head_ff[31]}}, pr_head_ff};
      lat_ext    = {{10{pr_lat_ff[31]}}, pr_lat_ff};
      // 1000 = 1024 - 16 - 8
      vis_sum    = (head_ext <<< 10) - (head_ext <<< 4) - (head_ext <<< 3) + (lat_ext <<< 6);
      num_sel    = pr_visual_ff ? vis_sum : head_ext;
      num_signed = cfg_steer_sign_ff ? (42'sd0 - num_sel) : num_sel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_valid_ff <= 1'b0;
      end else begin
         sc_valid_ff <= pr_valid_ff;
      end
      sc_tag_ff    <= pr_tag_ff;
      sc_visual_ff <= pr_visual_ff;
      sc_base_ff   <= pr_base_ff;
      sc_num_ff    <= num_signed[41:14];
   end

   // divide stage: floor division by 1000 for base and visual steering
   logic               st_valid_ff;
   tag_type            st_tag_ff;
   logic signed [19:0] st_base_ff;
   logic signed [17:0] st_steer_ff;
   logic signed [19:0] vis_quot;

   assign vis_quot = floor_div1000({sc_num_ff[27], sc_num_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff <= 1'b0;
      end else begin
         st_valid_ff <= sc_valid_ff;
      end
      st_tag_ff   <= sc_tag_ff;
      st_base_ff  <= floor_div1000(sc_base_ff);
      st_steer_ff <= sc_visual_ff ? vis_quot[17:0] : sc_num_ff[17:0];
   end

   // clamp steering and form the wheel frequencies
   logic signed [18:0] steer_ext;
   logic signed [18:0] steer_lim;
   logic signed [18:0] steer_clamped;
   logic signed [19:0] steer_wide;
   result_type         result_new;

   always_comb begin
      steer_ext = {st_steer_ff[17], st_steer_ff};
      steer_lim = {3'd0, cfg_max_steer_ff};
      if (steer_ext > steer_lim) begin
         steer_clamped = steer_lim;
      end else if (steer_ext < -steer_lim) begin
         steer_clamped = -steer_lim;
      end else begin
         steer_clamped = steer_ext;
      end
      steer_wide                    = {steer_clamped[18], steer_clamped};
      result_new.drive_enable       = st_tag_ff.drive_enable;
      result_new.left_freq_hz       = st_base_ff - steer_wide;
      result_new.right_freq_hz      = st_base_ff + steer_wide;
      result_new.control_mode       = st_tag_ff.control_mode;
      result_new.heading_hold_error = st_tag_ff.hold_error;
   end

   // result queue; credit keeps it from overflowing
   result_type       queue_mem [OUT_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] fill_ff;
   result_type       result_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
         credit_ff <= '0;
      end else begin
         if (st_valid_ff) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (rsp_acc) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         fill_ff   <= fill_ff + CNT_W'(st_valid_ff) - CNT_W'(rsp_acc);
         credit_ff <= credit_in;
      end
      if (st_valid_ff) begin
         queue_mem[wr_ptr_ff] <= result_new;
      end
   end

   assign credit_in = credit_ff + CNT_W'(req_acc) - CNT_W'(rsp_acc) - CNT_W'(nav_retire);

   assign result_head            = queue_mem[rd_ptr_ff];
   assign rsp_valid              = (fill_ff != '0);
   assign rsp_drive_enable       = result_head.drive_enable;
   assign rsp_left_freq_hz       = result_head.left_freq_hz;
   assign rsp_right_freq_hz      = result_head.right_freq_hz;
   assign rsp_control_mode       = result_head.control_mode;
   assign rsp_heading_hold_error = result_head.heading_hold_error;

   // checks
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= CNT_W'(OUT_DEPTH))
      else $error("credit count above queue depth");

   a_fill_within_credit: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= credit_ff)
      else $error("queue holds more results than claimed slots");

   a_nav_no_result: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && in_mode_ff == ITEM_NAV) |=> !op_valid_ff)
      else $error("navigation command produced a result");

   a_disabled_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_drive_enable) |-> (rsp_left_freq_hz == '0 && rsp_right_freq_hz == '0))
      else $error("stopped drive reports nonzero frequency");

   a_enabled_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_drive_enable) |-> (rsp_control_mode != RUN_STOPPED))
      else $error("driving result in stopped mode");

endmodule

[sim/tb_differential_steering_controller_unit.sv]
`timescale 1ns / 1ps

module tb_differential_steering_controller_unit;
   import dsc_pkg::*;

   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 9;
   localparam int SETTLE       = 12;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int NUM_PHASES   = 12;
   localparam int PHASE_ITEMS  = 160;
   localparam int HOLD_CYCLES  = 200;
   localparam int MAX_REPORTS  = 10;
   localparam int NUM_CSRS     = 7;
   localparam int NUM_ROWS     = 24;
   localparam longint AGE_MAX  = 65535;

   localparam logic [1:0] MODE_STOPPED = 2'd0;
   localparam logic [1:0] MODE_VISUAL  = 2'd1;
   localparam logic [1:0] MODE_HOLD    = 2'd2;

   localparam result_type IDLE_RESULT = '0;

   typedef struct {
      item_kind_type      kind;
      logic signed [15:0] velocity;
      logic signed [14:0] heading_error;
      logic signed [15:0] lateral_error;
      logic signed [14:0] imu_heading;
   } req_item_type;

   typedef struct {
      req_item_type item;
      bit           typed;
      result_type   want;
   } steer_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_mode = ITEM_BEGIN;
   logic signed [15:0] req_velocity_mm_s = '0;
   logic signed [14:0] req_heading_error = '0;
   logic signed [15:0] req_lateral_error_mm = '0;
   logic signed [14:0] req_imu_heading = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_drive_enable;
   logic signed [19:0] rsp_left_freq_hz;
   logic signed [19:0] rsp_right_freq_hz;
   logic [1:0]         rsp_control_mode;
   logic signed [14:0] rsp_heading_hold_error;
   logic               csr_wr_en = 1'b0;
   logic [2:0]         csr_index = CSR_MAX_VELOCITY;
   logic [15:0]        csr_wr_data = '0;

   // predictor copy of the configuration
   longint cfg_max_velocity, cfg_pulses, cfg_heading_gain, cfg_lateral_gain;
   longint cfg_max_steer, cfg_timeout;
   bit     cfg_negate;

   // predictor copy of the controller state
   logic [1:0] ctl_mode;
   longint     ctl_velocity, ctl_heading_err, ctl_lateral_err;
   longint     ctl_target, ctl_hold_err, ctl_age;

   result_type pending_drive [$];
   int         mismatch_count = 0;
   int         cycle_count = 0;
   int         send_idle_pct = 0;
   int         recv_idle_pct = 0;
   int         hold_request = 0;
   int         hold_served = 0;
   int         hold_left = 0;
   result_type seen_drive, want_drive;

   // directed rows: zero drive after reset, begin, stop and stopped ticks are typed in
   steer_row_type steer_rows [NUM_ROWS] = '{
      '{'{ITEM_TICK,       0,      0,      0,      0}, 1'b1, IDLE_RESULT},
      '{'{ITEM_BEGIN,      0,      0,      0,  11520}, 1'b1, IDLE_RESULT},
      '{'{ITEM_NAV,    32767,  11520,  32767,      0}, 1'b0, IDLE_RESULT},
      '{'{ITEM_TICK,       0,      0,      0,      0}, 1'b0, IDLE_RESULT},
      '{'{ITEM_TICK,       0,      0,      0, -11520}, 1'b0, IDLE_RESULT},
      '{'{ITEM_TICK,       0,      0,      0,  11520}, 1'b0, IDLE_RESULT},
      '{'{ITEM_TICK,       0,      0,      0,  16383}, 1'b0, IDLE_RESULT},
      '{'{ITEM_NAV,   -32768, -11520, -32768,      0}, 1'b0, IDLE_RESULT},
      '{'{ITEM_TICK,       0,      0,      0, -16384}, 1'b0, IDLE_RESULT},
      '{'{ITEM_TICK,       0,      0,      0, -16384}, 1'b0, IDLE_RESULT},
      '{'{ITEM_TICK,       0,      0,      0,  16383}, 1'b0, IDLE_RESULT},
      '{'{ITEM_TICK,       0,      0,      0,  -5000}, 1'b0, IDLE_RESULT},
      '{'{ITEM_STOP,       0,      0,      0,      0}, 1'b1, IDLE_RESULT},
      '{'{ITEM_TICK,       0,      0,      0,      0}, 1'b1, IDLE_RESULT},
      '{'{ITEM_NAV,       -1,     -1,     -1,      0}, 1'b0, IDLE_RESULT},
      '{'{ITEM_TICK,       0,      0,      0,      0}, 1'b0, IDLE_RESULT},
      '{'{ITEM_BEGIN,   1234,    777,   -555, -16384}, 1'b1, IDLE_RESULT},
      '{'{ITEM_TICK,     -99,     55,     66,    123}, 1'b1, IDLE_RESULT},
      '{'{ITEM_NAV,      500,  16383, -32768,      0}, 1'b0, IDLE_RESULT},
      '{'{ITEM_TICK,       0,      0,      0,      0}, 1'b0, IDLE_RESULT},
      '{'{ITEM_NAV,        1, -16384,  32767,      0}, 1'b0, IDLE_RESULT},
      '{'{ITEM_TICK,       0,      0,      0,   5000}, 1'b0, IDLE_RESULT},
      '{'{ITEM_TICK,       0,      0,      0,  16383}, 1'b0, IDLE_RESULT},
      '{'{ITEM_TICK,       0,      0,      0, -16384}, 1'b0, IDLE_RESULT}
   };

   differential_steering_controller_unit u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_mode              (req_mode),
      .req_velocity_mm_s     (req_velocity_mm_s),
      .req_heading_error     (req_heading_error),
      .req_lateral_error_mm  (req_lateral_error_mm),
      .req_imu_heading       (req_imu_heading),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_drive_enable      (rsp_drive_enable),
      .rsp_left_freq_hz      (rsp_left_freq_hz),
      .rsp_right_freq_hz     (rsp_right_freq_hz),
      .rsp_control_mode      (rsp_control_mode),
      .rsp_heading_hold_error(rsp_heading_hold_error),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_index),
      .csr_wr_data           (csr_wr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_differential_steering_controller_unit: done, errors");
         $finish;
      end
   end

   // division rounding toward minus infinity
   function automatic longint floor_div(input longint num, input longint den);
      longint quo;
      quo = num / den;
      if ((num % den) != 0 && num < 0)
         quo = quo - 1;
      return quo;
   endfunction

   // bring a heading difference into half a turn either way
   function automatic longint wrap_angle(input longint ang);
      while (ang > longint'(WRAP_HALF))
         ang = ang - longint'(WRAP_FULL);
      while (ang < -longint'(WRAP_HALF))
         ang = ang + longint'(WRAP_FULL);
      return ang;
   endfunction

   function automatic void reset_drive_model();
      ctl_mode        = MODE_STOPPED;
      ctl_velocity    = 0;
      ctl_heading_err = 0;
      ctl_lateral_err = 0;
      ctl_hold_err    = 0;
   endfunction

   // controller state update; returns 1 when the item gives a drive item
   function automatic bit predict_drive(input req_item_type it, output result_type res);
      longint imu, vel, base, num, steer;
      imu = longint'(it.imu_heading);
      res = '0;
      case (it.kind)
         ITEM_BEGIN, ITEM_STOP: begin
            reset_drive_model();
            if (it.kind == ITEM_BEGIN)
               ctl_target = imu;
            ctl_age = 0;
            return 1'b1;
         end
         ITEM_NAV: begin
            vel = longint'(it.velocity);
            if (vel > cfg_max_velocity)
               vel = cfg_max_velocity;
            if (vel < -cfg_max_velocity)
               vel = -cfg_max_velocity;
            ctl_velocity    = vel;
            ctl_heading_err = longint'(it.heading_error);
            ctl_lateral_err = longint'(it.lateral_error);
            ctl_age         = 0;
            ctl_mode        = MODE_VISUAL;
            return 1'b0;
         end
         default: begin
            if (ctl_age < AGE_MAX)
               ctl_age = ctl_age + 1;
            if (ctl_mode != MODE_VISUAL && ctl_mode != MODE_HOLD) begin
               ctl_mode = MODE_STOPPED;
               res.heading_hold_error = 15'(ctl_hold_err);
               return 1'b1;
            end
            base = floor_div(ctl_velocity * cfg_pulses, 1000);
            if (ctl_mode == MODE_VISUAL && ctl_age <= cfg_timeout) begin
               num = cfg_heading_gain * ctl_heading_err * 1000
                   + cfg_lateral_gain * ctl_lateral_err * 64;
               if (cfg_negate)
                  num = -num;
               steer = floor_div(num, 16384000);
            end else begin
               // visual command went stale: latch the heading and hold it
               if (ctl_mode == MODE_VISUAL) begin
                  ctl_target      = imu;
                  ctl_heading_err = 0;
                  ctl_lateral_err = 0;
                  ctl_mode        = MODE_HOLD;
               end
               ctl_hold_err = wrap_angle(ctl_target - imu);
               num = cfg_heading_gain * ctl_hold_err;
               if (cfg_negate)
                  num = -num;
               steer = floor_div(num, 16384);
            end
            if (steer > cfg_max_steer)
               steer = cfg_max_steer;
            if (steer < -cfg_max_steer)
               steer = -cfg_max_steer;
            res.drive_enable       = 1'b1;
            res.left_freq_hz       = 20'(base - steer);
            res.right_freq_hz      = 20'(base + steer);
            res.control_mode       = ctl_mode;
            res.heading_hold_error = 15'(ctl_hold_err);
            return 1'b1;
         end
      endcase
   endfunction

   // register write, mirrored into the predictor
   task automatic write_reg(input csr_index_type idx, input logic [15:0] data);
      csr_wr_en   = 1'b1;
      csr_index   = idx;
      csr_wr_data = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
      case (idx)
         CSR_MAX_VELOCITY: cfg_max_velocity = longint'(data[11:0]);
         CSR_PULSES_PER_M: cfg_pulses       = longint'(data);
         CSR_HEADING_GAIN: cfg_heading_gain = longint'(data);
         CSR_LATERAL_GAIN: cfg_lateral_gain = longint'(data);
         CSR_MAX_STEERING: cfg_max_steer    = longint'(data);
         CSR_STEER_SIGN:   cfg_negate       = data[0];
         CSR_TIMEOUT:      cfg_timeout      = longint'(data);
         default: ;
      endcase
   endtask

   // offer one item, entered and left at a falling edge
   task automatic send_item(input req_item_type it, input bit typed, input result_type want);
      result_type res;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_mode             = it.kind;
      req_velocity_mm_s    = it.velocity;
      req_heading_error    = it.heading_error;
      req_lateral_error_mm = it.lateral_error;
      req_imu_heading      = it.imu_heading;
      req_valid            = 1'b1;
      do
         @(posedge clock);
      while (req_stall);
      if (predict_drive(it, res))
         pending_drive.push_back(typed ? want : res);
      @(negedge clock);
   endtask

   // wait until every drive item is back and the pipeline is empty
   task automatic drain();
      req_valid = 1'b0;
      while (pending_drive.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // heading-like field, mostly within half a turn, sometimes anywhere
   function automatic logic signed [14:0] random_angle();
      if ($urandom_range(0, 99) < 85)
         return 15'(int'($urandom_range(0, 23040)) - 11520);
      return 15'($urandom);
   endfunction

   function automatic req_item_type random_item();
      req_item_type it;
      int unsigned  pick;
      pick = $urandom_range(0, 99);
      if (pick < 4)
         it.kind = ITEM_BEGIN;
      else if (pick < 8)
         it.kind = ITEM_STOP;
      else if (pick < 18)
         it.kind = ITEM_NAV;
      else
         it.kind = ITEM_TICK;
      if ($urandom_range(0, 1))
         it.velocity = 16'($urandom);
      else
         it.velocity = 16'(int'($urandom_range(0, 9000)) - 4500);
      it.heading_error = random_angle();
      if ($urandom_range(0, 1))
         it.lateral_error = 16'($urandom);
      else
         it.lateral_error = 16'(int'($urandom_range(0, 6000)) - 3000);
      it.imu_heading = random_angle();
      return it;
   endfunction

   // per-phase register settings, extremes in a few phases
   task automatic configure_phase(input int phase);
      logic [15:0] vals [NUM_CSRS];
      case (phase)
         0: vals = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001, 16'h0000};
         4: vals = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF};
         8: vals = '{16'h0FFF, 16'hFFFF, 16'h0001, 16'h0001, 16'hFFFF, 16'hFFFE, 16'h0003};
         default: begin
            vals[CSR_MAX_VELOCITY] = $urandom_range(0, 1) ? 16'($urandom)
                                                         : 16'($urandom_range(100, 3000));
            vals[CSR_PULSES_PER_M] = $urandom_range(0, 1) ? 16'($urandom)
                                                         : 16'($urandom_range(500, 3000));
            vals[CSR_HEADING_GAIN] = $urandom_range(0, 3) != 0 ? 16'($urandom_range(0, 2048))
                                                              : 16'($urandom);
            vals[CSR_LATERAL_GAIN] = $urandom_range(0, 3) != 0 ? 16'($urandom_range(0, 2048))
                                                              : 16'($urandom);
            vals[CSR_MAX_STEERING] = $urandom_range(0, 1) ? 16'($urandom_range(0, 2000))
                                                         : 16'($urandom);
            vals[CSR_STEER_SIGN]   = 16'($urandom);
            vals[CSR_TIMEOUT]      = $urandom_range(0, 99) < 80 ? 16'($urandom_range(0, 12))
                                                               : 16'($urandom);
         end
      endcase
      for (int i = 0; i < NUM_CSRS; i++)
         write_reg(csr_index_type'(i), vals[i]);
   endtask

   task automatic report_error(input string what, input result_type want,
                               input result_type got);
      if (mismatch_count < MAX_REPORTS)
         $display({"%s: expected en=%0b l=%0d r=%0d mode=%0d hold=%0d,",
                   " got en=%0b l=%0d r=%0d mode=%0d hold=%0d"},
                  what, want.drive_enable, $signed(want.left_freq_hz),
                  $signed(want.right_freq_hz), want.control_mode,
                  $signed(want.heading_hold_error), got.drive_enable,
                  $signed(got.left_freq_hz), $signed(got.right_freq_hz),
                  got.control_mode, $signed(got.heading_hold_error));
      mismatch_count = mismatch_count + 1;
   endtask

   // receiver stall: long hold-off on request, otherwise random
   always @(negedge clock) begin
      if (hold_request != hold_served) begin
         hold_served = hold_request;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall = ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // compare each accepted drive item with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_drive = '{rsp_drive_enable, rsp_left_freq_hz, rsp_right_freq_hz,
                        rsp_control_mode, rsp_heading_hold_error};
         if (pending_drive.size() == 0) begin
            report_error("unexpected item", IDLE_RESULT, seen_drive);
         end else begin
            want_drive = pending_drive.pop_front();
            if (seen_drive.drive_enable !== want_drive.drive_enable
                || seen_drive.left_freq_hz !== want_drive.left_freq_hz
                || seen_drive.right_freq_hz !== want_drive.right_freq_hz
                || seen_drive.control_mode !== want_drive.control_mode
                || seen_drive.heading_hold_error !== want_drive.heading_hold_error)
               report_error("drive mismatch", want_drive, seen_drive);
         end
      end
   end

   // main sequence
   initial begin
      cfg_max_velocity = longint'(RST_MAX_VELOCITY);
      cfg_pulses       = longint'(RST_PULSES_PER_M);
      cfg_heading_gain = longint'(RST_HEADING_GAIN);
      cfg_lateral_gain = longint'(RST_LATERAL_GAIN);
      cfg_max_steer    = longint'(RST_MAX_STEERING);
      cfg_negate       = RST_STEER_SIGN;
      cfg_timeout      = longint'(RST_TIMEOUT);
      reset_drive_model();
      ctl_target = 0;
      ctl_age    = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // directed part: short timeout so fresh and stale ticks both show,
      // tight steering limit so the first visual tick clamps
      send_idle_pct = 32;
      recv_idle_pct = 76;
      write_reg(CSR_TIMEOUT, 16'd1);
      write_reg(CSR_MAX_STEERING, 16'd200);
      for (int i = 0; i < NUM_ROWS; i++)
         send_item(steer_rows[i].item, steer_rows[i].typed, steer_rows[i].want);
      drain();

      // random phases
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase < NUM_PHASES / 3) begin
            send_idle_pct = 32;
            recv_idle_pct = 76;
         end else if (phase < 2 * NUM_PHASES / 3) begin
            send_idle_pct = 76;
            recv_idle_pct = 32;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         configure_phase(phase);
         if (phase == NUM_PHASES - 2)
            hold_request = hold_request + 1;
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_item(random_item(), 1'b0, IDLE_RESULT);
         drain();
      end

      if (mismatch_count == 0)
         $display("tb_differential_steering_controller_unit: done, clean");
      else
         $display("tb_differential_steering_controller_unit: done, errors");
      $finish;
   end

endmodule
